// ===== src/dip_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dip_pkg
// Shared types, constants and the rounding function of the double power block.
// ----------------------------------------------------------------------------
package dip_pkg;

    localparam logic [62:0] TOL_RESET  = 63'h3E7AD7F29ABCAF48;
    localparam logic [63:0] ONE_BITS   = 64'h3FF0000000000000;
    localparam logic [62:0] INF_MAG    = 63'h7FF0000000000000;
    localparam logic [63:0] QNAN_BITS  = 64'hFFF8000000000000;
    localparam logic [63:0] QUIET_BIT  = 64'h0008000000000000;
    localparam int          STEP_W     = 6;
    localparam logic [5:0]  DIV_STEPS  = 6'd54;
    localparam logic [5:0]  MUL_STEPS  = 6'd4;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } fpu_op_t;

    typedef struct packed {
        logic    start;
        fpu_op_t op;
    } fpu_req_t;

    typedef struct packed {
        logic done;
    } fpu_rsp_t;

    // Rounds p * 2^(x - 1127), with an extra sticky bit, to a double.
    function automatic logic [63:0] round_pack(
        input logic               sign,
        input logic signed [13:0] x,
        input logic [105:0]       p,
        input logic               stk
    );
        logic signed [13:0] r;
        logic signed [13:0] s_wide;
        logic [6:0]         s;
        logic [105:0]       shifted;
        logic [105:0]       gtmp;
        logic [105:0]       mask;
        logic [53:0]        m;
        logic [54:0]        mr;
        logic               g;
        logic               sticky;
        logic [10:0]        expf;
        logic [62:0]        mag;
        begin
            r = x + {13'd0, p[105]};
            if (r >= 14'sd1)
            begin
                s_wide = 14'sd52 + {13'd0, p[105]};
            end
            else
            begin
                s_wide = 14'sd53 + {13'd0, p[105]} - r;
            end
            if (s_wide > 14'sd110)
            begin
                s = 7'd110;
            end
            else
            begin
                s = s_wide[6:0];
            end
            shifted = p >> s;
            gtmp    = p >> (s - 7'd1);
            mask    = (106'd1 << (s - 7'd1)) - 106'd1;
            m       = shifted[53:0];
            g       = gtmp[0];
            sticky  = stk | ((p & mask) != 106'd0);
            mr      = {1'b0, m} + {54'd0, g & (sticky | m[0])};
            if (r >= 14'sd1)
            begin
                expf = r[10:0] - 11'd1;
            end
            else
            begin
                expf = 11'd0;
            end
            mag = {expf, 52'd0} + {8'd0, mr};
            if (r > 14'sd2046)
            begin
                round_pack = {sign, INF_MAG};
            end
            else
            begin
                round_pack = {sign, mag};
            end
        end
    endfunction

endpackage
`default_nettype wire

// ===== src/double_integer_power.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// double_integer_power
// Raises a double base to a signed 32-bit exponent by repeated squaring.
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  input     base_bits, exponent            start & !busy
//  result    result_bits, invalid           done, one cycle
//  config    cfg_data                       cfg_we
//
//  An item runs up to 60 multiplies on the shared unit: the sequencer scans
//  for the top exponent bit, squares once per lower bit and multiplies by
//  the base where that bit is set, then takes the reciprocal for a negative
//  exponent; subnormal operands are normalized by single-bit shifts first.
//  Reset clears the sequencer and loads the tolerance with 1e-7.
//  The result is shown for one cycle and cannot be held off.
module double_integer_power (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] base_bits,
    input  wire logic signed [31:0] exponent,
    output logic             done,
    output logic [63:0]      result_bits,
    output logic             invalid,
    input  wire logic        cfg_we,
    input  wire logic [62:0] cfg_data
);

    typedef enum logic [6:0] {
        T_IDLE = 7'b0000001,
        T_SCAN = 7'b0000010,
        T_LOOP = 7'b0000100,
        T_SQW  = 7'b0001000,
        T_MW   = 7'b0010000,
        T_DW   = 7'b0100000,
        T_OUT  = 7'b1000000
    } tstate_t;

    tstate_t           state_reg, state_next;
    logic [62:0]       tol_reg, tol_next;
    logic [63:0]       base_reg, base_next;
    logic [63:0]       acc_reg, acc_next;
    logic [31:0]       bits_reg, bits_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic              mulbit_reg, mulbit_next;
    logic [63:0]       out_reg, out_next;
    logic              inv_reg, inv_next;

    dip_pkg::fpu_req_t req;
    dip_pkg::fpu_rsp_t rsp;
    logic [63:0]       fa, fb, fres;
    logic              base_nan, tol_nan, near_zero;
    logic [31:0]       mag;

    assign base_nan  = (base_bits[62:52] == 11'h7FF) && (base_bits[51:0] != 52'd0);
    assign tol_nan   = (tol_reg[62:52] == 11'h7FF) && (tol_reg[51:0] != 52'd0);
    assign near_zero = !base_nan && !tol_nan && (base_bits[62:0] < tol_reg);
    assign mag       = exponent[31] ? (32'd0 - exponent) : exponent;

    dip_fpu u_fpu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .a     (fa),
        .b     (fb),
        .rsp   (rsp),
        .res   (fres)
    );

    always_comb
    begin
        state_next  = state_reg;
        tol_next    = cfg_we ? cfg_data : tol_reg;
        base_next   = base_reg;
        acc_next    = acc_reg;
        bits_next   = bits_reg;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        mulbit_next = mulbit_reg;
        out_next    = out_reg;
        inv_next    = inv_reg;
        req.start   = 1'b0;
        req.op      = dip_pkg::OP_MUL;
        fa          = acc_reg;
        fb          = acc_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (start)
                begin
                    base_next = base_bits;
                    neg_next  = exponent[31];
                    bits_next = mag;
                    cnt_next  = 5'd31;
                    inv_next  = 1'b0;
                    if (exponent[31] && near_zero)
                    begin
                        out_next   = 64'd0;
                        inv_next   = 1'b1;
                        state_next = T_OUT;
                    end
                    else if (mag == 32'd0)
                    begin
                        out_next   = dip_pkg::ONE_BITS;
                        state_next = T_OUT;
                    end
                    else
                    begin
                        state_next = T_SCAN;
                    end
                end
            end
            T_SCAN:
            begin
                if (bits_reg[31])
                begin
                    acc_next   = base_reg;
                    state_next = T_LOOP;
                end
                else
                begin
                    bits_next = bits_reg << 1;
                    cnt_next  = cnt_reg - 5'd1;
                end
            end
            T_LOOP:
            begin
                if (cnt_reg == 5'd0)
                begin
                    if (neg_reg)
                    begin
                        req.start  = 1'b1;
                        req.op     = dip_pkg::OP_DIV;
                        state_next = T_DW;
                    end
                    else
                    begin
                        out_next   = acc_reg;
                        state_next = T_OUT;
                    end
                end
                else
                begin
                    req.start   = 1'b1;
                    cnt_next    = cnt_reg - 5'd1;
                    bits_next   = bits_reg << 1;
                    mulbit_next = bits_reg[30];
                    state_next  = T_SQW;
                end
            end
            T_SQW:
            begin
                fa = fres;
                fb = base_reg;
                if (rsp.done)
                begin
                    acc_next = fres;
                    if (mulbit_reg)
                    begin
                        req.start  = 1'b1;
                        state_next = T_MW;
                    end
                    else
                    begin
                        state_next = T_LOOP;
                    end
                end
            end
            T_MW:
            begin
                if (rsp.done)
                begin
                    acc_next   = fres;
                    state_next = T_LOOP;
                end
            end
            T_DW:
            begin
                if (rsp.done)
                begin
                    out_next   = fres;
                    state_next = T_OUT;
                end
            end
            T_OUT:
            begin
                state_next = T_IDLE;
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            tol_reg   <= dip_pkg::TOL_RESET;
        end
        else
        begin
            state_reg <= state_next;
            tol_reg   <= tol_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg   <= base_next;
        acc_reg    <= acc_next;
        bits_reg   <= bits_next;
        cnt_reg    <= cnt_next;
        neg_reg    <= neg_next;
        mulbit_reg <= mulbit_next;
        out_reg    <= out_next;
        inv_reg    <= inv_next;
    end

    assign busy        = (state_reg != T_IDLE);
    assign done        = (state_reg == T_OUT);
    assign result_bits = out_reg;
    assign invalid     = inv_reg;

endmodule
`default_nettype wire

// ===== src/dip_fpu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dip_fpu
// Iterative double multiplier and reciprocal unit shared by the sequencer.
// ----------------------------------------------------------------------------
module dip_fpu (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire dip_pkg::fpu_req_t req,
    input  wire logic [63:0]      a,
    input  wire logic [63:0]      b,
    output dip_pkg::fpu_rsp_t     rsp,
    output logic [63:0]           res
);

    typedef enum logic [6:0] {
        U_IDLE   = 7'b0000001,
        U_NORM_A = 7'b0000010,
        U_NORM_B = 7'b0000100,
        U_MUL    = 7'b0001000,
        U_DIV    = 7'b0010000,
        U_ROUND  = 7'b0100000,
        U_DONE   = 7'b1000000
    } ustate_t;

    ustate_t            state_reg, state_next;
    dip_pkg::fpu_op_t   op_reg, op_next;
    logic [52:0]        ma_reg, ma_next;
    logic [52:0]        mb_reg, mb_next;
    logic signed [13:0] ea_reg, ea_next;
    logic signed [13:0] eb_reg, eb_next;
    logic signed [13:0] x_reg, x_next;
    logic               sign_reg, sign_next;
    logic               stk_reg, stk_next;
    logic [105:0]       acc_reg, acc_next;
    logic [53:0]        pp_reg, pp_next;
    logic [1:0]         ppsh_reg, ppsh_next;
    logic [5:0]         step_reg, step_next;
    logic [53:0]        rem_reg, rem_next;
    logic [54:0]        q_reg, q_next;
    logic [63:0]        res_reg, res_next;

    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [26:0] opx, opy;
    logic [105:0] pp_shifted;

    assign a_nan  = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
    assign b_nan  = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
    assign a_inf  = (a[62:52] == 11'h7FF) && (a[51:0] == 52'd0);
    assign b_inf  = (b[62:52] == 11'h7FF) && (b[51:0] == 52'd0);
    assign a_zero = (a[62:0] == 63'd0);
    assign b_zero = (b[62:0] == 63'd0);

    assign opx = step_reg[1] ? {1'b0, ma_reg[52:27]} : ma_reg[26:0];
    assign opy = step_reg[0] ? {1'b0, mb_reg[52:27]} : mb_reg[26:0];

    always_comb
    begin
        case (ppsh_reg)
            2'd0:    pp_shifted = {52'd0, pp_reg};
            2'd1:    pp_shifted = {52'd0, pp_reg} << 27;
            default: pp_shifted = {52'd0, pp_reg} << 54;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        ea_next    = ea_reg;
        eb_next    = eb_reg;
        x_next     = x_reg;
        sign_next  = sign_reg;
        stk_next   = stk_reg;
        acc_next   = acc_reg;
        pp_next    = pp_reg;
        ppsh_next  = ppsh_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        res_next   = res_reg;
        case (state_reg)
            U_IDLE, U_DONE:
            begin
                state_next = U_IDLE;
                if (req.start)
                begin
                    op_next   = req.op;
                    ma_next   = {a[62:52] != 11'd0, a[51:0]};
                    mb_next   = {b[62:52] != 11'd0, b[51:0]};
                    ea_next   = (a[62:52] == 11'd0) ? 14'sd1 : {3'd0, a[62:52]};
                    eb_next   = (b[62:52] == 11'd0) ? 14'sd1 : {3'd0, b[62:52]};
                    state_next = U_NORM_A;
                    if (req.op == dip_pkg::OP_DIV)
                    begin
                        sign_next = a[63];
                        if (a_nan)
                        begin
                            res_next   = a | dip_pkg::QUIET_BIT;
                            state_next = U_DONE;
                        end
                        else if (a_inf)
                        begin
                            res_next   = {a[63], 63'd0};
                            state_next = U_DONE;
                        end
                        else if (a_zero)
                        begin
                            res_next   = {a[63], dip_pkg::INF_MAG};
                            state_next = U_DONE;
                        end
                    end
                    else
                    begin
                        sign_next = a[63] ^ b[63];
                        if (a_nan)
                        begin
                            res_next   = a | dip_pkg::QUIET_BIT;
                            state_next = U_DONE;
                        end
                        else if (b_nan)
                        begin
                            res_next   = b | dip_pkg::QUIET_BIT;
                            state_next = U_DONE;
                        end
                        else if ((a_inf && b_zero) || (b_inf && a_zero))
                        begin
                            res_next   = dip_pkg::QNAN_BITS;
                            state_next = U_DONE;
                        end
                        else if (a_inf || b_inf)
                        begin
                            res_next   = {a[63] ^ b[63], dip_pkg::INF_MAG};
                            state_next = U_DONE;
                        end
                        else if (a_zero || b_zero)
                        begin
                            res_next   = {a[63] ^ b[63], 63'd0};
                            state_next = U_DONE;
                        end
                    end
                end
            end
            U_NORM_A:
            begin
                if (ma_reg[52])
                begin
                    step_next = '0;
                    if (op_reg == dip_pkg::OP_DIV)
                    begin
                        rem_next   = 54'd1 << 52;
                        q_next     = '0;
                        state_next = U_DIV;
                    end
                    else
                    begin
                        state_next = U_NORM_B;
                    end
                end
                else
                begin
                    ma_next = ma_reg << 1;
                    ea_next = ea_reg - 14'sd1;
                end
            end
            U_NORM_B:
            begin
                if (mb_reg[52])
                begin
                    step_next  = '0;
                    acc_next   = '0;
                    state_next = U_MUL;
                end
                else
                begin
                    mb_next = mb_reg << 1;
                    eb_next = eb_reg - 14'sd1;
                end
            end
            U_MUL:
            begin
                pp_next   = {27'd0, opx} * {27'd0, opy};
                ppsh_next = (step_reg == 6'd0) ? 2'd0 : ((step_reg == 6'd3) ? 2'd2 : 2'd1);
                if (step_reg != 6'd0)
                begin
                    acc_next = acc_reg + pp_shifted;
                end
                step_next = step_reg + 6'd1;
                if (step_reg == dip_pkg::MUL_STEPS)
                begin
                    x_next     = ea_reg + eb_reg - 14'sd1023;
                    stk_next   = 1'b0;
                    state_next = U_ROUND;
                end
            end
            U_DIV:
            begin
                if (rem_reg >= {1'b0, ma_reg})
                begin
                    q_next   = {q_reg[53:0], 1'b1};
                    rem_next = (rem_reg - {1'b0, ma_reg}) << 1;
                end
                else
                begin
                    q_next   = {q_reg[53:0], 1'b0};
                    rem_next = rem_reg << 1;
                end
                step_next = step_reg + 6'd1;
                if (step_reg == dip_pkg::DIV_STEPS)
                begin
                    state_next = U_ROUND;
                end
            end
            U_ROUND:
            begin
                if (op_reg == dip_pkg::OP_DIV)
                begin
                    res_next = dip_pkg::round_pack(sign_reg, 14'sd2045 - ea_reg,
                                                   {q_reg, 51'd0}, rem_reg != 54'd0);
                end
                else
                begin
                    res_next = dip_pkg::round_pack(sign_reg, x_reg, acc_reg, stk_reg);
                end
                state_next = U_DONE;
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        ea_reg   <= ea_next;
        eb_reg   <= eb_next;
        x_reg    <= x_next;
        sign_reg <= sign_next;
        stk_reg  <= stk_next;
        acc_reg  <= acc_next;
        pp_reg   <= pp_next;
        ppsh_reg <= ppsh_next;
        step_reg <= step_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        res_reg  <= res_next;
    end

    assign rsp.done = (state_reg == U_DONE);
    assign res      = res_reg;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Checks the double integer power block against a real-valued predictor.
// Directed and random bases and exponents are sent under several tolerance
// settings with random sender gaps, and every result is compared bit for bit.
// ----------------------------------------------------------------------------
module tb;

    typedef struct {
        logic [63:0] result_bits;
        logic        invalid;
    } power_t;

    class power_scoreboard;
        power_t      pending[$];
        logic [62:0] tolerance;
        int          errors;

        function new();
            tolerance = dip_pkg::TOL_RESET;
            errors    = 0;
        endfunction

        function real raise(real b, logic [31:0] m);
            real acc;
            int  top;
            begin
                if (m == 32'd0)
                begin
                    return 1.0;
                end
                top = 31;
                while (m[top] == 1'b0)
                begin
                    top--;
                end
                acc = b;
                while (top > 0)
                begin
                    top--;
                    acc = acc * acc;
                    if (m[top])
                    begin
                        acc = acc * b;
                    end
                end
                return acc;
            end
        endfunction

        function void note_item(logic [63:0] b, logic signed [31:0] e);
            power_t      p;
            logic [31:0] m;
            logic [63:0] rb;
            real         r;
            begin
                p.invalid     = 1'b0;
                p.result_bits = 64'd0;
                if (e < 0 && $bitstoreal({1'b0, b[62:0]}) < $bitstoreal({1'b0, tolerance}))
                begin
                    p.invalid = 1'b1;
                end
                else
                begin
                    m  = e[31] ? 32'd0 - e : e;
                    r  = raise($bitstoreal(b), m);
                    rb = $realtobits(r);
                    if (e[31])
                    begin
                        if (rb[62:0] == 63'd0)
                        begin
                            rb = {rb[63], dip_pkg::INF_MAG};
                        end
                        else
                        begin
                            rb = $realtobits(1.0 / r);
                        end
                    end
                    p.result_bits = rb;
                end
                pending.push_back(p);
            end
        endfunction

        function void check_result(logic [63:0] rb, logic inv);
            power_t p;
            begin
                if (pending.size() == 0)
                begin
                    $display("%0t: unexpected result %h invalid %b", $time, rb, inv);
                    errors++;
                end
                else
                begin
                    p = pending.pop_front();
                    if (p.result_bits !== rb)
                    begin
                        $display("%0t: result_bits expected %h actual %h", $time,
                                 p.result_bits, rb);
                        errors++;
                    end
                    if (p.invalid !== inv)
                    begin
                        $display("%0t: invalid expected %b actual %b", $time,
                                 p.invalid, inv);
                        errors++;
                    end
                end
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [63:0]        base_bits = 64'd0;
    logic signed [31:0] exponent = 32'sd0;
    logic               done;
    logic [63:0]        result_bits;
    logic               invalid;
    logic               cfg_we = 1'b0;
    logic [62:0]        cfg_data = 63'd0;

    power_scoreboard sb = new();
    int              idle_pct = 0;
    int              quiet_cycles = 0;

    always #4 clk = ~clk;

    double_integer_power u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .base_bits   (base_bits),
        .exponent    (exponent),
        .done        (done),
        .result_bits (result_bits),
        .invalid     (invalid),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data)
    );

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            sb.check_result(result_bits, invalid);
        end
        if ((start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles > 20000)
        begin
            $display("** double_integer_power: FAILED **");
            $finish;
        end
    end

    task automatic send_item(logic [63:0] b, logic signed [31:0] e);
        int gap;
        begin
            gap = 0;
            while ($urandom_range(99, 0) < idle_pct && gap < 20)
            begin
                gap++;
            end
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            start     <= 1'b1;
            base_bits <= b;
            exponent  <= e;
            do
            begin
                @(posedge clk);
            end
            while (busy);
            sb.note_item(b, e);
        end
    endtask

    task automatic drain();
        begin
            start <= 1'b0;
            @(posedge clk);
            while (sb.pending.size() != 0)
            begin
                @(posedge clk);
            end
            repeat (5) @(posedge clk);
        end
    endtask

    task automatic write_tolerance(logic [62:0] v);
        begin
            cfg_we   <= 1'b1;
            cfg_data <= v;
            @(posedge clk);
            cfg_we   <= 1'b0;
            sb.tolerance = v;
            @(posedge clk);
        end
    endtask

    function automatic logic [63:0] random_base();
        logic [63:0] b;
        begin
            b = {$urandom(), $urandom()};
            case ($urandom_range(5, 0))
                0, 1: b[62:52] = 11'h3FE + 11'($urandom_range(1, 0));
                2:    b[62:52] = 11'($urandom_range(1100, 950));
                3:    b[62:52] = 11'($urandom_range(3, 0));
                default: ;
            endcase
            return b;
        end
    endfunction

    function automatic logic signed [31:0] random_exponent();
        begin
            if ($urandom_range(4, 0) == 0)
            begin
                return $urandom();
            end
            return $signed($urandom_range(80, 0)) - 32'sd40;
        end
    endfunction

    task automatic random_items(int n);
        begin
            repeat (n) send_item(random_base(), random_exponent());
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 14;
        send_item(64'h0000000000000000, 32'sd0);
        send_item(64'h8000000000000000, -32'sd1);
        send_item(64'h0000000000000000, 32'sd3);
        send_item(64'h3FF0000000000000, 32'sh80000000);
        send_item(64'hBFF0000000000000, 32'sh7FFFFFFF);
        send_item(64'h4000000000000000, 32'sd1023);
        send_item(64'h4000000000000000, 32'sd1024);
        send_item(64'h4000000000000000, -32'sd1074);
        send_item(64'h4000000000000000, -32'sd1080);
        send_item(64'h3FE0000000000000, 32'sd1074);
        send_item(64'h0000000000000001, 32'sd1);
        send_item(64'h0000000000000001, -32'sd1);
        send_item(64'h7FEFFFFFFFFFFFFF, 32'sd2);
        send_item(64'h7FEFFFFFFFFFFFFF, -32'sd2);
        send_item(64'h7FF0000000000000, -32'sd3);
        send_item(64'hFFF0000000000000, 32'sd3);
        send_item(64'h7FF8000000000000, -32'sd5);
        send_item(64'h3E7AD7F29ABCAF48, -32'sd1);
        send_item(64'h3E7AD7F29ABCAF47, -32'sd1);
        send_item(64'hBE7AD7F29ABCAF47, 32'sd2);
        send_item(64'hC008000000000000, -32'sd7);
        send_item(64'h3FF0000000000001, 32'sh80000000);
        random_items(250);
        drain();

        idle_pct = 48;
        write_tolerance(63'd0);
        send_item(64'h0000000000000000, -32'sd1);
        random_items(200);
        drain();
        write_tolerance(63'h7FEFFFFFFFFFFFFF);
        random_items(200);
        drain();

        idle_pct = 0;
        write_tolerance(63'h3FF0000000000000);
        random_items(200);
        drain();
        write_tolerance(dip_pkg::TOL_RESET);
        random_items(180);
        drain();

        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
        begin
            $display("** double_integer_power: PASSED **");
        end
        else
        begin
            $display("** double_integer_power: FAILED **");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
src/dip_pkg.sv
src/dip_fpu.sv
src/double_integer_power.sv
tb/tb.sv
